[src/mws_pkg.sv]
package mws_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // wave codes
    localparam logic [2:0] WAVE_CONST    = 3'd0;
    localparam logic [2:0] WAVE_NOP      = 3'd1;
    localparam logic [2:0] WAVE_SINE     = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd4;
    localparam logic [2:0] WAVE_NOISE    = 3'd5;

    // noise generator
    localparam logic [31:0] LFSR_SEED = 32'h0000_0001;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // quarter-wave sine polynomial coefficients, Q20
    localparam int unsigned QS_A = 1647099;
    localparam int unsigned QS_B = 677341;
    localparam int unsigned QS_C = 83563;

    // shared divider widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 34;
    localparam int DIV_CW = $clog2(DIV_NW);

    localparam int TDATA_W = 184;

    // input tdata layout, last member in the lowest bits
    typedef struct packed {
        logic [2:0]         pad;
        logic [30:0]        tick;
        logic [15:0]        pulse;
        logic signed [15:0] bias;
        logic signed [15:0] amplitude;
        logic [15:0]        period_ticks;
        logic [15:0]        fade_ticks;
        logic [30:0]        end_tick;
        logic [30:0]        start_tick;
        logic [2:0]         wave_code;
        logic [2:0]         slot_index;
        logic [1:0]         track_index;
    } t_in_data;

    typedef struct packed {
        logic [2:0]         wave;
        logic [30:0]        s_begin;
        logic [30:0]        s_finish;
        logic [15:0]        fade;
        logic [15:0]        period;
        logic signed [15:0] amp;
        logic signed [15:0] bias;
        logic [15:0]        pulse;
    } t_slot;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

endpackage

[src/mws_div.sv]
module mws_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mws_pkg::t_div_req i_req,
    output mws_pkg::t_div_rsp o_rsp
);
    import mws_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_r;
    logic [DIV_DW-1:0] r_d;
    logic [DIV_DW:0]   n_try;
    logic              n_fit;

    // restoring division, one quotient bit a cycle
    assign n_try = {r_r, r_q[DIV_NW-1]};
    assign n_fit = (n_try >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.dividend;
                r_r    <= '0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                r_r <= n_fit ? DIV_DW'(n_try - {1'b0, r_d}) : n_try[DIV_DW-1:0];
                r_q <= {r_q[DIV_NW-2:0], n_fit};
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

[src/multitrack_wave_synth_voice.sv]
// Multitrack wave synth voice. A slot table of NUM_TRACKS x SLOTS_PER_TRACK
// waveform operations sits in one synchronous memory; a write transfer fills
// a slot and a clear transfer empties it. A tick transfer walks every slot in
// order; a slot that is empty or outside its tick window is skipped, and an
// active constant, nop or noise slot needs no division. The other waves go
// through one shared restoring divider with a 48-bit dividend: square uses one
// division for the phase, triangle a second division for the slope, sine a
// second division for the table index plus a short polynomial, and a slot
// still inside its crossfade one more for the fade division. Every slot a
// crossfading sine is the worst case. The iterative divider sets nearly all
// of a tick's time. The sample then waits in an output register while the
// next transfer may already be taken.
module multitrack_wave_synth_voice #(
    parameter int NUM_TRACKS       = 4,
    parameter int SLOTS_PER_TRACK  = 8,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // fields from bit 0: track_index, slot_index, wave_code, start_tick,
    // end_tick, fade_ticks, period_ticks, amplitude, bias, pulse, tick, zero pad
    input  logic [mws_pkg::TDATA_W-1:0]  s_axis_tdata,
    // fields from bit 0: command
    input  logic [1:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // fields from bit 0: sample
    output logic [15:0]                  m_axis_tdata
);
    import mws_pkg::*;

    localparam int NSLOTS = NUM_TRACKS * SLOTS_PER_TRACK;
    localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int KW     = (SLOTS_PER_TRACK > 1) ? $clog2(SLOTS_PER_TRACK) : 1;
    localparam int TW     = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int IW     = $clog2(SINE_TABLE_DEPTH);
    localparam int PW     = IW + 2;
    localparam logic [PW-1:0] SD1 = PW'(SINE_TABLE_DEPTH);
    localparam logic [PW-1:0] SD2 = PW'(2 * SINE_TABLE_DEPTH);
    localparam logic [PW-1:0] SD3 = PW'(3 * SINE_TABLE_DEPTH);
    // reciprocal of the table depth, 2^39 / depth rounded up; exact for the
    // position within a quarter once the product is shifted down by 24
    localparam logic [33:0] ZREC = 34'(((64'd1 << 39) + 64'(SINE_TABLE_DEPTH) - 64'd1)
                                     / 64'(SINE_TABLE_DEPTH));

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_CHECK, S_PH, S_PH_W, S_LIM, S_SHAPE,
        S_SIN_W, S_SIN_Z, S_SIN_ZW, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5,
        S_TRI_DEN, S_TRI_DIV, S_TRI_W, S_SCALE, S_SCALE2,
        S_MIX, S_FADE, S_FADE_W, S_NEXT, S_VOICE, S_VSAT,
        S_OUT, S_OSAT, S_EMIT
    } t_state;

    t_state r_state;

    // slot table
    t_slot mem [NSLOTS];
    t_slot r_slot;
    logic [NSLOTS-1:0] r_valid;
    logic r_slot_on;

    t_in_data w_in;
    logic     w_acc;
    logic     w_in_range;
    logic [AW-1:0] w_waddr;
    logic     w_we;
    t_slot    w_wdata;

    // walk and datapath registers
    logic [30:0]        r_now;
    logic [AW-1:0]      r_addr;
    logic [KW-1:0]      r_k;
    logic [TW-1:0]      r_t;
    logic [30:0]        r_d;
    logic [15:0]        r_period;
    logic [15:0]        r_ph;
    logic [31:0]        r_num;
    logic [31:0]        r_lim;
    logic [32:0]        r_den;
    logic               r_rise;
    logic [1:0]         r_quad;
    logic [PW-1:0]      r_sin_r;
    logic [15:0]        r_z;
    logic [15:0]        r_z2;
    logic signed [17:0] r_e;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_prod2;
    logic               r_neg;
    logic signed [19:0] r_w;
    logic signed [19:0] r_track;
    logic signed [31:0] r_voice;
    logic [15:0]        r_smp;
    logic [31:0]        r_lfsr;
    logic               r_m_valid;
    logic [15:0]        r_m_data;

    t_div_req r_div;
    t_div_rsp w_div;

    logic [31:0]        n_lfsr;
    logic [IW-1:0]      w_idx;
    logic [PW-1:0]      w_p;
    logic [1:0]         w_quad;
    logic [PW-1:0]      w_rem;
    logic signed [63:0] w_fade_sum;
    logic signed [63:0] w_trunc;
    logic signed [63:0] w_round;
    logic [15:0]        w_qs;
    logic [16:0]        w_s;

    // product divided by 32768, rounded toward zero
    function automatic logic signed [63:0] f_trunc15(input logic signed [63:0] x);
        return (x + (x[63] ? 64'sd32767 : 64'sd0)) >>> 15;
    endfunction

    mws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div),
        .o_rsp   (w_div)
    );

    assign w_in          = t_in_data'(s_axis_tdata);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_in_range    = (32'(w_in.track_index) < NUM_TRACKS)
                        && (32'(w_in.slot_index) < SLOTS_PER_TRACK);
    assign w_waddr       = AW'(32'(w_in.track_index) * SLOTS_PER_TRACK
                        + 32'(w_in.slot_index));
    assign w_we          = w_acc && (s_axis_tuser == CMD_WRITE) && w_in_range;

    assign w_wdata.wave     = w_in.wave_code;
    assign w_wdata.s_begin  = w_in.start_tick;
    assign w_wdata.s_finish = w_in.end_tick;
    assign w_wdata.fade     = w_in.fade_ticks;
    assign w_wdata.period   = w_in.period_ticks;
    assign w_wdata.amp      = w_in.amplitude;
    assign w_wdata.bias     = w_in.bias;
    assign w_wdata.pulse    = w_in.pulse;

    // writes only happen while idle, so the walk never sees a slot change
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_READ) begin
            r_slot <= mem[r_addr];
        end
    end

    // galois step of the noise generator
    always_comb begin
        n_lfsr = r_lfsr >> 1;
        if (r_lfsr[0]) begin
            n_lfsr = n_lfsr ^ LFSR_TAPS;
        end
    end

    // sine table index split into quarter and position within it
    assign w_idx = w_div.quot[IW-1:0];
    assign w_p   = {w_idx, 2'b00};
    always_comb begin
        priority if (w_p >= SD3) begin
            w_quad = 2'd3;
            w_rem  = w_p - SD3;
        end else if (w_p >= SD2) begin
            w_quad = 2'd2;
            w_rem  = w_p - SD2;
        end else if (w_p >= SD1) begin
            w_quad = 2'd1;
            w_rem  = w_p - SD1;
        end else begin
            w_quad = 2'd0;
            w_rem  = w_p;
        end
    end

    assign w_fade_sum = r_prod + r_prod2;
    assign w_trunc    = f_trunc15(r_prod);
    assign w_round    = (r_prod + 64'sd524288) >>> 20;
    assign w_qs       = (w_round > 64'sd32767) ? 16'd32767 : w_round[15:0];
    assign w_s        = r_rise ? w_div.quot[16:0] : 17'd32768 - w_div.quot[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_lfsr    <= LFSR_SEED;
            r_m_valid <= 1'b0;
            r_div     <= '0;
        end else begin
            // start is a one-cycle pulse; no state that raises it follows one that did
            if (r_div.start) begin
                r_div.start <= 1'b0;
            end
            // the emit state reloads the output register itself
            if (r_m_valid && m_axis_tready && (r_state != S_EMIT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        priority if (s_axis_tuser == CMD_WRITE) begin
                            if (w_in_range) begin
                                r_valid[w_waddr] <= 1'b1;
                            end
                        end else if (s_axis_tuser == CMD_CLEAR) begin
                            if (w_in_range) begin
                                r_valid[w_waddr] <= 1'b0;
                            end
                        end else if (s_axis_tuser == CMD_TICK) begin
                            r_now   <= w_in.tick;
                            r_addr  <= '0;
                            r_k     <= '0;
                            r_t     <= '0;
                            r_track <= 20'sd32768;
                            r_voice <= 32'sd32768;
                            r_state <= S_READ;
                        end else begin
                            // unknown command, dropped
                        end
                    end
                end
                S_READ: begin
                    r_slot_on <= r_valid[r_addr];
                    r_state   <= S_CHECK;
                end
                S_CHECK: begin
                    if (!r_slot_on || (r_now < r_slot.s_begin)
                            || (r_now >= r_slot.s_finish)) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_d      <= r_now - r_slot.s_begin;
                        r_period <= (r_slot.period == 16'd0) ? 16'd1 : r_slot.period;
                        unique case (r_slot.wave)
                            WAVE_CONST: begin
                                r_w     <= 20'(r_slot.amp) + 20'(r_slot.bias);
                                r_state <= S_MIX;
                            end
                            WAVE_NOISE: begin
                                r_lfsr  <= n_lfsr;
                                r_w     <= $signed({4'b0, n_lfsr[15:0]}) - 20'sd32767;
                                r_state <= S_MIX;
                            end
                            WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE: begin
                                r_state <= S_PH;
                            end
                            default: begin
                                r_w     <= '0;
                                r_state <= S_MIX;
                            end
                        endcase
                    end
                end
                S_PH: begin
                    r_div.start    <= 1'b1;
                    r_div.dividend <= DIV_NW'(r_d);
                    r_div.divisor  <= DIV_DW'(r_period);
                    r_state        <= S_PH_W;
                end
                S_PH_W: begin
                    if (w_div.done) begin
                        r_ph    <= w_div.rem[15:0];
                        r_state <= S_LIM;
                    end
                end
                S_LIM: begin
                    r_num   <= {r_ph, 16'b0};
                    r_lim   <= 32'(r_slot.pulse) * 32'(r_period);
                    r_state <= S_SHAPE;
                end
                S_SHAPE: begin
                    unique case (r_slot.wave)
                        WAVE_SQUARE: begin
                            r_w <= (r_num <= r_lim)
                                 ? 20'(r_slot.amp) + 20'(r_slot.bias)
                                 : 20'(r_slot.bias) - 20'(r_slot.amp);
                            r_state <= S_MIX;
                        end
                        WAVE_SINE: begin
                            r_div.start    <= 1'b1;
                            r_div.dividend <= DIV_NW'(r_ph) * DIV_NW'(SINE_TABLE_DEPTH);
                            r_div.divisor  <= DIV_DW'(r_period);
                            r_state        <= S_SIN_W;
                        end
                        default: begin
                            // triangle: rising or falling edge
                            if (r_num < r_lim) begin
                                r_rise         <= 1'b1;
                                r_div.start    <= 1'b1;
                                r_div.dividend <= DIV_NW'({r_num, 15'b0});
                                r_div.divisor  <= DIV_DW'(r_lim);
                                r_state        <= S_TRI_W;
                            end else begin
                                r_rise  <= 1'b0;
                                r_state <= S_TRI_DEN;
                            end
                        end
                    endcase
                end
                S_SIN_W: begin
                    if (w_div.done) begin
                        r_quad  <= w_quad;
                        r_sin_r <= w_rem;
                        r_state <= S_SIN_Z;
                    end
                end
                S_SIN_Z: begin
                    // position within the quarter scaled to q15 by reciprocal
                    r_prod  <= signed'(64'(r_sin_r) * 64'(ZREC));
                    r_state <= S_SIN_ZW;
                end
                S_SIN_ZW: begin
                    // odd quarters run the polynomial backwards
                    r_z <= r_quad[0]
                         ? 16'(17'd32768 - {1'b0, r_prod[39:24]})
                         : r_prod[39:24];
                    r_state <= S_Q1;
                end
                S_Q1: begin
                    r_prod  <= signed'(64'(r_z) * 64'(r_z));
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    r_z2    <= r_prod[30:15];
                    r_prod  <= signed'(64'(r_prod[30:15]) * 64'(QS_C));
                    r_state <= S_Q3;
                end
                S_Q3: begin
                    r_prod  <= signed'(64'(r_z2) * (64'(QS_B) - (64'(r_prod) >> 15)));
                    r_state <= S_Q4;
                end
                S_Q4: begin
                    r_prod  <= signed'(64'(r_z) * (64'(QS_A) - (64'(r_prod) >> 15)));
                    r_state <= S_Q5;
                end
                S_Q5: begin
                    r_e     <= r_quad[1] ? -$signed({2'b0, w_qs}) : $signed({2'b0, w_qs});
                    r_state <= S_SCALE;
                end
                S_TRI_DEN: begin
                    r_den   <= 33'(17'h10000 - {1'b0, r_slot.pulse}) * 33'(r_period);
                    r_state <= S_TRI_DIV;
                end
                S_TRI_DIV: begin
                    r_div.start    <= 1'b1;
                    r_div.dividend <= DIV_NW'({r_num - r_lim, 15'b0});
                    r_div.divisor  <= DIV_DW'(r_den);
                    r_state        <= S_TRI_W;
                end
                S_TRI_W: begin
                    if (w_div.done) begin
                        r_e     <= $signed({w_s, 1'b0}) - 18'sd32768;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_prod  <= 64'(r_e) * 64'(r_slot.amp);
                    r_state <= S_SCALE2;
                end
                S_SCALE2: begin
                    r_w     <= 20'(w_trunc) + 20'(r_slot.bias);
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    if (r_d < 31'(r_slot.fade)) begin
                        r_prod  <= 64'(r_w) * signed'(64'(r_d));
                        r_prod2 <= 64'(r_track)
                                 * signed'(64'(16'(r_slot.fade - r_d[15:0])));
                        r_state <= S_FADE;
                    end else begin
                        r_track <= r_w;
                        r_state <= S_NEXT;
                    end
                end
                S_FADE: begin
                    r_neg          <= w_fade_sum[63];
                    r_div.start    <= 1'b1;
                    r_div.dividend <= DIV_NW'(w_fade_sum[63] ? -w_fade_sum : w_fade_sum);
                    r_div.divisor  <= DIV_DW'(r_slot.fade);
                    r_state        <= S_FADE_W;
                end
                S_FADE_W: begin
                    if (w_div.done) begin
                        r_track <= r_neg ? -$signed(w_div.quot[19:0])
                                         : $signed(w_div.quot[19:0]);
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_k == KW'(SLOTS_PER_TRACK - 1)) begin
                        r_state <= S_VOICE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_VOICE: begin
                    r_prod  <= 64'(r_voice) * 64'(r_track);
                    r_state <= S_VSAT;
                end
                S_VSAT: begin
                    // voice saturates to 32 bits after every track
                    if (w_trunc > 64'sd2147483647) begin
                        r_voice <= 32'sh7FFF_FFFF;
                    end else if (w_trunc < -64'sd2147483648) begin
                        r_voice <= 32'sh8000_0000;
                    end else begin
                        r_voice <= w_trunc[31:0];
                    end
                    r_track <= 20'sd32768;
                    if (r_t == TW'(NUM_TRACKS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_t     <= r_t + 1'b1;
                        r_k     <= '0;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    r_prod  <= 64'(r_voice) * 64'sd32767;
                    r_state <= S_OSAT;
                end
                S_OSAT: begin
                    if (w_trunc > 64'sd32767) begin
                        r_smp <= 16'h7FFF;
                    end else if (w_trunc < -64'sd32768) begin
                        r_smp <= 16'h8000;
                    end else begin
                        r_smp <= w_trunc[15:0];
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_smp;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

[bench/multitrack_wave_synth_voice_test.sv]
module multitrack_wave_synth_voice_test;
    import mws_pkg::*;

    localparam int TRACKS = 4;
    localparam int SLOTS  = 8;
    localparam int SINE_N = 1024;
    localparam int ONE    = 32768;

    typedef struct packed {
        logic [1:0] cmd;
        t_in_data   d;
    } t_transfer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // fields from bit 0: track_index, slot_index, wave_code, start_tick,
    // end_tick, fade_ticks, period_ticks, amplitude, bias, pulse, tick, zero pad
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    // fields from bit 0: command
    logic [1:0]          s_axis_tuser = CMD_TICK;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // fields from bit 0: sample
    logic [15:0]         m_axis_tdata;

    multitrack_wave_synth_voice dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow slot table, indexed track*SLOTS+slot
    t_slot       shadow_slot [TRACKS*SLOTS];
    bit          shadow_live [TRACKS*SLOTS];
    logic [31:0] shadow_lfsr;

    t_transfer   pending_transfers[$];
    logic [15:0] expected_samples[$];
    t_transfer   on_bus;

    int  mismatches = 0;
    int  ticks_sent = 0;
    int  writes_sent = 0;
    int  samples_seen = 0;
    bit  quiet = 1'b0;         // no idling in the closing part of the run
    bit  hold_sink = 1'b0;     // long receiver stall, set from its own process
    int  src_gap = 0;
    int  sink_gap = 0;

    // sin(pi/2 * z) for z in q15, rounded, clipped to 32767
    function automatic longint quarter_sin(longint z);
        longint z2, inner, poly, r;
        z2    = (z * z) / ONE;
        inner = longint'(QS_B) - (z2 * longint'(QS_C)) / ONE;
        poly  = longint'(QS_A) - (z2 * inner) / ONE;
        r     = (z * poly + (64'sd1 <<< 19)) >>> 20;
        return (r > 32767) ? 32767 : r;
    endfunction

    function automatic longint sine_at(longint idx);
        longint p, q, r, z, v;
        p = (idx % SINE_N) * 4;
        q = p / SINE_N;
        r = p - q * SINE_N;
        z = (r * ONE) / SINE_N;
        v = (q == 0 || q == 2) ? quarter_sin(z) : quarter_sin(ONE - z);
        return (q >= 2) ? -v : v;
    endfunction

    // value of one active slot at the given tick; noise steps the lfsr
    function automatic longint slot_wave_value(int s, longint now);
        longint amp, bias, per, ph, num, lim, den, sv;
        bit     lsb;
        amp  = shadow_slot[s].amp;
        bias = shadow_slot[s].bias;
        case (shadow_slot[s].wave)
            WAVE_CONST: return amp + bias;
            WAVE_NOISE: begin
                lsb = shadow_lfsr[0];
                shadow_lfsr = shadow_lfsr >> 1;
                if (lsb) shadow_lfsr = shadow_lfsr ^ LFSR_TAPS;
                return longint'(shadow_lfsr[15:0]) - 32767;
            end
            WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE: begin
                per = (shadow_slot[s].period == 0) ? 1 : shadow_slot[s].period;
                ph  = (now - longint'(shadow_slot[s].s_begin)) % per;
                num = ph * 65536;
                lim = longint'(shadow_slot[s].pulse) * per;
                if (shadow_slot[s].wave == WAVE_SINE)
                    return (sine_at((ph * SINE_N) / per) * amp) / ONE + bias;
                if (shadow_slot[s].wave == WAVE_SQUARE)
                    return (num <= lim) ? amp + bias : -amp + bias;
                if (num < lim) begin
                    sv = (num * ONE) / lim;
                end else begin
                    den = (65536 - longint'(shadow_slot[s].pulse)) * per;
                    sv  = ONE - ((num - lim) * ONE) / den;
                end
                return ((2 * sv - ONE) * amp) / ONE + bias;
            end
            default: return 0;   // nop and the unused codes
        endcase
    endfunction

    // applies one accepted transfer to the shadow table; ticks queue a sample
    function automatic void apply_transfer(t_transfer x);
        int     s, t, k;
        longint now, voice, trk, w, dlt, f, smp;
        s = x.d.track_index * SLOTS + x.d.slot_index;
        case (x.cmd)
            CMD_WRITE: begin
                shadow_live[s] = 1'b1;
                shadow_slot[s].wave     = x.d.wave_code;
                shadow_slot[s].s_begin  = x.d.start_tick;
                shadow_slot[s].s_finish = x.d.end_tick;
                shadow_slot[s].fade     = x.d.fade_ticks;
                shadow_slot[s].period   = x.d.period_ticks;
                shadow_slot[s].amp      = x.d.amplitude;
                shadow_slot[s].bias     = x.d.bias;
                shadow_slot[s].pulse    = x.d.pulse;
            end
            CMD_CLEAR: shadow_live[s] = 1'b0;
            CMD_TICK: begin
                now   = x.d.tick;
                voice = ONE;
                for (t = 0; t < TRACKS; t++) begin
                    trk = ONE;
                    for (k = 0; k < SLOTS; k++) begin
                        s = t * SLOTS + k;
                        if (!shadow_live[s]) continue;
                        if (now < shadow_slot[s].s_begin || now >= shadow_slot[s].s_finish)
                            continue;
                        w   = slot_wave_value(s, now);
                        dlt = now - longint'(shadow_slot[s].s_begin);
                        f   = shadow_slot[s].fade;
                        trk = (dlt < f) ? (w * dlt + trk * (f - dlt)) / f : w;
                    end
                    voice = (voice * trk) / ONE;
                    if (voice > 64'sd2147483647) voice = 64'sd2147483647;
                    if (voice < -64'sd2147483648) voice = -64'sd2147483648;
                end
                smp = (voice * 32767) / ONE;
                if (smp > 32767) smp = 32767;
                if (smp < -32768) smp = -32768;
                expected_samples.push_back(smp[15:0]);
            end
            default: ;   // unknown command does nothing
        endcase
    endfunction

    // source side: one nonblocking write per signal per edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) apply_transfer(on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_transfers.size() > 0) begin
                    on_bus = pending_transfers.pop_front();
                    quiet  = (pending_transfers.size() < 100);
                    s_axis_tdata  <= on_bus.d;
                    s_axis_tuser  <= on_bus.cmd;
                    s_axis_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 5);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: random stall bursts plus the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_sink) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 5);
        end
    end

    // sample checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample transfer %0d", $signed(m_axis_tdata));
            end else if (m_axis_tdata !== expected_samples[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sample mismatch: expected %0d got %0d",
                             $signed(expected_samples[0]), $signed(m_axis_tdata));
                void'(expected_samples.pop_front());
            end else begin
                void'(expected_samples.pop_front());
            end
        end
    end

    function automatic t_transfer slot_write(int trk, int slt, logic [2:0] wave,
                                             int unsigned st, int unsigned en,
                                             int fade, int per, int amp, int bias,
                                             int pulse);
        t_transfer x;
        x = '0;
        x.cmd            = CMD_WRITE;
        x.d.track_index  = 2'(trk);
        x.d.slot_index   = 3'(slt);
        x.d.wave_code    = wave;
        x.d.start_tick   = 31'(st);
        x.d.end_tick     = 31'(en);
        x.d.fade_ticks   = 16'(fade);
        x.d.period_ticks = 16'(per);
        x.d.amplitude    = 16'(amp);
        x.d.bias         = 16'(bias);
        x.d.pulse        = 16'(pulse);
        return x;
    endfunction

    function automatic t_transfer tick_at(int unsigned tk);
        t_transfer x;
        x = '0;
        x.cmd    = CMD_TICK;
        x.d.tick = 31'(tk);
        return x;
    endfunction

    // random junk in every field but the zero pad, command chosen by caller
    function automatic t_transfer noise_transfer(logic [1:0] cmd);
        t_transfer    x;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        x = raw[$bits(t_transfer)-1:0];
        x.cmd   = cmd;
        x.d.pad = '0;
        return x;
    endfunction

    task automatic add(t_transfer x);
        pending_transfers.push_back(x);
        if (x.cmd == CMD_TICK) ticks_sent++;
        if (x.cmd == CMD_WRITE) writes_sent++;
    endtask

    initial begin
        int          n, i, base, span;
        t_transfer   x;
        logic [2:0]  wv;
        for (i = 0; i < TRACKS * SLOTS; i++) shadow_live[i] = 1'b0;
        shadow_lfsr = LFSR_SEED;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, each wave kind, extremes, crossfade, odd codes
        add(tick_at(0));
        add(slot_write(0, 0, WAVE_CONST, 0, 31'h7FFF_FFFF, 0, 1, 32767, 32767, 0));
        add(tick_at(31'h7FFF_FFFE));
        add(tick_at(31'h7FFF_FFFF));     // end is exclusive
        add(slot_write(1, 7, WAVE_CONST, 10, 20, 0, 1, -32768, -32768, 0));
        add(tick_at(10));                // strong negative times positive, saturates
        add(tick_at(20));
        add(slot_write(1, 7, WAVE_SINE, 100, 5000, 0, 1000, 32767, 0, 0));
        add(tick_at(350));
        add(slot_write(2, 3, WAVE_SQUARE, 100, 5000, 0, 0, 20000, -1000, 65535));
        add(tick_at(400));               // zero period acts as one
        add(slot_write(2, 4, WAVE_TRIANGLE, 100, 5000, 16, 65535, -32768, 5, 0));
        add(tick_at(105));               // within crossfade, pulse zero
        add(slot_write(3, 0, WAVE_NOISE, 0, 6000, 0, 7, 1, 1, 1));
        add(tick_at(500));
        add(tick_at(501));
        add(slot_write(3, 1, 3'd6, 0, 6000, 65535, 7, 1, 1, 1));
        add(slot_write(3, 2, 3'd7, 50, 40, 0, 7, 1, 1, 1));  // never active
        add(tick_at(502));
        add(noise_transfer(2'd3));       // unknown command
        add(slot_write(0, 1, WAVE_NOP, 0, 6000, 0, 1, 0, 0, 0));
        add(tick_at(503));
        for (i = 0; i < TRACKS; i++) begin
            x = '0; x.cmd = CMD_CLEAR; x.d.track_index = 2'(i); x.d.slot_index = 7;
            add(x);
        end
        add(tick_at(504));

        // random: write a few slots around a moving base tick, then tick inside
        base = 1000;
        n = 0;
        while (n < 930) begin
            if ($urandom_range(0, 9) == 0) base = $urandom_range(0, 31'h7FFF_0000);
            else base += $urandom_range(0, 3000);
            repeat ($urandom_range(1, 4)) begin
                wv = 3'($urandom_range(0, 7));
                span = $urandom_range(1, 4000);
                x = noise_transfer(CMD_WRITE);
                x.d.wave_code = wv;
                if ($urandom_range(0, 7) != 0) begin
                    x.d.start_tick = 31'(base) - 31'($urandom_range(0, 200));
                    x.d.end_tick   = x.d.start_tick + 31'(span);
                    if ($urandom_range(0, 2) != 0)
                        x.d.fade_ticks = 16'($urandom_range(0, 300));
                    if ($urandom_range(0, 1) != 0)
                        x.d.period_ticks = 16'($urandom_range(0, 500));
                end
                add(x);
                n++;
            end
            repeat ($urandom_range(1, 6)) begin
                add(tick_at(base + $urandom_range(0, 400)));
                n++;
            end
            case ($urandom_range(0, 9))
                0: begin add(noise_transfer(CMD_CLEAR)); n++; end
                1: begin add(noise_transfer(2'd3)); n++; end
                2: begin add(noise_transfer(CMD_TICK)); n++; end
                default: ;
            endcase
        end

        wait (pending_transfers.size() == 0 && !s_axis_tvalid && expected_samples.size() == 0);
        repeat (8000) @(posedge i_clk);
        $display("%0d ticks and %0d slot writes sent, %0d samples checked, %0d mismatches",
                 ticks_sent, writes_sent, samples_seen, mismatches);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // long receiver hold-off while the source keeps offering transfers
    initial begin
        repeat (3000) @(posedge i_clk);
        hold_sink = 1'b1;
        repeat (20000) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    initial begin
        #(10 * 30_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
